// ----- design/bbcg_pkg.sv -----
// Shared types, constants and helpers of the Butterworth biquad coefficient generator.
// No dependencies; imported by bbcg_front, bbcg_back and the top level.
`timescale 1ns / 1ps
`default_nettype none

package bbcg_pkg;

  localparam int unsigned COEF_FRAC_BITS = 30;
  localparam int unsigned WORK_BITS      = 30;
  localparam int unsigned TAYLOR_TERMS   = 8;

  localparam logic [31:0] PI_Q30    = 32'hC90FDAA2;
  localparam logic [30:0] SQRT2_Q30 = 31'd1518500250;
  localparam logic [36:0] ONE_W     = 37'd1 << WORK_BITS;

  localparam int unsigned RECIP5_SHIFT = 35;
  localparam logic [32:0] RECIP5 = 33'(((66'd1 << RECIP5_SHIFT) + 66'd4) / 66'd5);

  localparam int unsigned FQ_DEPTH = 4;
  localparam int unsigned FQ_AW    = $clog2(FQ_DEPTH);

  localparam int unsigned XDIV_STEPS = 32;
  localparam int unsigned OHM_STEPS  = 32;
  localparam int unsigned COEF_STEPS = COEF_FRAC_BITS + 1;
  localparam int unsigned CW         = 36;

  localparam int unsigned ST_IN       = 0;
  localparam int unsigned ST_XDIV_END = ST_IN + XDIV_STEPS;
  localparam int unsigned ST_THETA    = ST_XDIV_END + 1;
  localparam int unsigned ST_TH2      = ST_THETA + 1;
  localparam int unsigned ST_TAY_END  = ST_TH2 + 2 * TAYLOR_TERMS;
  localparam int unsigned ST_CLAMP    = ST_TAY_END + 1;
  localparam int unsigned ST_OHM_END  = ST_CLAMP + OHM_STEPS;
  localparam int unsigned ST_SQ       = ST_OHM_END + 1;
  localparam int unsigned ST_NUM      = ST_SQ + 1;
  localparam int unsigned ST_COEF_END = ST_NUM + COEF_STEPS;
  localparam int unsigned NUM_STAGES  = ST_COEF_END + 1;

  typedef struct packed {
    logic [23:0] fs;
    logic [23:0] fc;
    logic        pt;
  } req_t;

  typedef struct packed {
    logic [23:0] fc;
    logic        pt;
  } meta_t;

  typedef struct packed {
    logic [31:0] b0;
    logic [31:0] b1;
    logic [31:0] b2;
    logic [31:0] a1;
    logic [31:0] a2;
    logic [23:0] fc;
    logic        pt;
  } res_t;

  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    logic [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'h7FFFFFFF;
    end else if (v < -34'sd2147483648) begin
      r = 32'h80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/bbcg_front.sv -----
// Front end: accepts requests, clamps the cutoff to 0.4 of the sample rate, flags
// pass-through and holds the classified requests in a short queue. Uses bbcg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bbcg_front
  import bbcg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [23:0] sample_rate,
  input  logic [23:0] cutoff_request,
  output logic        req_valid,
  output req_t        req,
  input  logic        req_pop
);

  req_t             fq_r [FQ_DEPTH];
  logic [FQ_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [FQ_AW:0]   cnt_r, cnt_nxt;
  logic [57:0]      lim_prod;
  logic [23:0]      limit;
  logic [23:0]      fc;
  logic             wr_en, rd_en;

  always_comb begin
    lim_prod = 58'({sample_rate, 1'b0}) * 58'(RECIP5);
    limit    = 24'(lim_prod >> RECIP5_SHIFT);
    fc       = (cutoff_request < limit) ? cutoff_request : limit;
  end

  assign full      = (cnt_r == (FQ_AW + 1)'(FQ_DEPTH));
  assign req_valid = (cnt_r != '0);
  assign req       = fq_r[rp_r];
  assign wr_en     = push && !full;
  assign rd_en     = req_pop && req_valid;

  always_comb begin
    wp_nxt  = wr_en ? wp_r + 1'b1 : wp_r;
    rp_nxt  = rd_en ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (FQ_AW + 1)'(wr_en) - (FQ_AW + 1)'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fq_r[wp_r] <= '{fs: sample_rate, fc: fc, pt: (fc == 24'd0)};
    end
  end

endmodule

`default_nettype wire

// ----- design/bbcg_back.sv -----
// Back end: pipelined ratio divider, sine and cosine by Taylor series, ohm divider and
// coefficient dividers, then saturation into a two-entry result queue. Uses bbcg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bbcg_back
  import bbcg_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic req_valid,
  input  req_t req,
  output logic req_pop,
  input  logic res_pop,
  output logic res_empty,
  output res_t res
);

  localparam int unsigned TS = 2 * TAYLOR_TERMS;

  logic  v_r [NUM_STAGES];
  meta_t m_r [NUM_STAGES];
  logic  en;

  // ratio divider fc * 2^32 / fs
  logic [23:0] xr_r [XDIV_STEPS+1];
  logic [31:0] xq_r [XDIV_STEPS+1];
  logic [23:0] xd_r [XDIV_STEPS];

  // Taylor lanes
  logic [31:0] st_r [TS];
  logic [31:0] ct_r [TS];
  logic [33:0] sa_r [TS+1];
  logic [33:0] ca_r [TS+1];
  logic [31:0] tt_r [TS];
  logic [31:0] theta_r;

  // ohm divider
  logic [31:0] hr_r [OHM_STEPS+1];
  logic [31:0] hq_r [OHM_STEPS+1];
  logic [31:0] hn_r [OHM_STEPS];
  logic [31:0] hd_r [OHM_STEPS];

  logic [34:0] ohm2_r;
  logic [33:0] s2o_r;

  // coefficient dividers: b0, a1 / 2, a2
  logic [CW-1:0]           cr_r [COEF_STEPS+1][3];
  logic [COEF_FRAC_BITS:0] cq_r [COEF_STEPS+1][3];
  logic [COEF_FRAC_BITS:0] cn_r [COEF_STEPS][3];
  logic                    cs_r [COEF_STEPS+1][3];
  logic [CW-1:0]           cd_r [COEF_STEPS];

  // result queue
  res_t rq_r [2];
  logic rq_wp_r, rq_rp_r;
  logic [1:0] rq_cnt_r;
  logic rq_full, rq_push, rq_pop;
  res_t fin;

  assign rq_full   = (rq_cnt_r == 2'd2);
  assign en        = !(rq_full && v_r[NUM_STAGES-1]);
  assign req_pop   = en && req_valid;
  assign res_empty = (rq_cnt_r == 2'd0);
  assign res       = rq_r[rq_rp_r];
  assign rq_push   = en && v_r[NUM_STAGES-1];
  assign rq_pop    = res_pop && !res_empty;

  // valid and metadata line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_STAGES; s++) v_r[s] <= 1'b0;
    end else if (en) begin
      v_r[0] <= req_valid;
      for (int s = 1; s < NUM_STAGES; s++) v_r[s] <= v_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0] <= '{fc: req.fc, pt: req.pt};
      for (int s = 1; s < NUM_STAGES; s++) m_r[s] <= m_r[s-1];
    end
  end

  // stage in
  always_ff @(posedge clk) begin
    if (en) begin
      xr_r[0] <= req.fc;
      xq_r[0] <= '0;
      xd_r[0] <= req.fs;
    end
  end

  for (genvar j = 1; j <= XDIV_STEPS; j++) begin : g_xdiv
    logic [24:0] rem2;
    logic        ge;
    always_comb begin
      rem2 = {xr_r[j-1], 1'b0};
      ge   = (rem2 >= {1'b0, xd_r[j-1]});
    end
    always_ff @(posedge clk) begin
      if (en) begin
        xr_r[j] <= ge ? 24'(rem2 - {1'b0, xd_r[j-1]}) : rem2[23:0];
        xq_r[j] <= {xq_r[j-1][30:0], ge};
      end
    end
    if (j < XDIV_STEPS) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) xd_r[j] <= xd_r[j-1];
      end
    end
  end

  // theta and its square
  logic [64:0] th_prod;
  logic [63:0] th2_prod;
  always_comb begin
    th_prod  = 65'(xq_r[XDIV_STEPS]) * 65'(PI_Q30) + (65'd1 << 31);
    th2_prod = 64'(theta_r) * 64'(theta_r) + (64'd1 << (WORK_BITS - 1));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      theta_r <= 32'(th_prod >> 32);
      st_r[0] <= theta_r;
      sa_r[0] <= 34'(theta_r);
      ct_r[0] <= ONE_W[31:0];
      ca_r[0] <= ONE_W[33:0];
      tt_r[0] <= 32'(th2_prod >> WORK_BITS);
    end
  end

  for (genvar k = 1; k <= TAYLOR_TERMS; k++) begin : g_tay
    localparam int unsigned JA = 2 * k - 1;
    localparam int unsigned JB = 2 * k;
    localparam int unsigned SD = (2 * k) * (2 * k + 1);
    localparam int unsigned CD = (2 * k - 1) * (2 * k);
    localparam int unsigned SL = $clog2(SD);
    localparam int unsigned CL = $clog2(CD);
    localparam logic [32:0] SM = 33'(((66'd1 << (32 + SL)) + 66'(SD) - 66'd1) / 66'(SD));
    localparam logic [32:0] CM = 33'(((66'd1 << (32 + CL)) + 66'(CD) - 66'd1) / 66'(CD));
    localparam logic SUB = ((k % 2) == 1);

    logic [63:0] sp_a, cp_a;
    logic [64:0] sp_b, cp_b;
    logic [31:0] sq_b, cq_b;

    always_comb begin
      sp_a = 64'(st_r[JA-1]) * 64'(tt_r[JA-1]);
      cp_a = 64'(ct_r[JA-1]) * 64'(tt_r[JA-1]);
      sp_b = 65'(st_r[JA]) * 65'(SM);
      cp_b = 65'(ct_r[JA]) * 65'(CM);
      sq_b = 32'(sp_b >> (32 + SL));
      cq_b = 32'(cp_b >> (32 + CL));
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[JA] <= 32'(sp_a >> WORK_BITS);
        ct_r[JA] <= 32'(cp_a >> WORK_BITS);
        sa_r[JA] <= sa_r[JA-1];
        ca_r[JA] <= ca_r[JA-1];
        tt_r[JA] <= tt_r[JA-1];
        sa_r[JB] <= SUB ? sa_r[JA] - 34'(sq_b) : sa_r[JA] + 34'(sq_b);
        ca_r[JB] <= SUB ? ca_r[JA] - 34'(cq_b) : ca_r[JA] + 34'(cq_b);
      end
    end

    if (JB < TS) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) begin
          st_r[JB] <= sq_b;
          ct_r[JB] <= cq_b;
          tt_r[JB] <= tt_r[JA];
        end
      end
    end
  end

  // clamp sine and cosine, start ohm division
  logic [31:0] sn, cs;
  logic [61:0] hnum;
  always_comb begin
    sn   = sa_r[TS][33] ? 32'd0 : sa_r[TS][31:0];
    cs   = ($signed(ca_r[TS]) < 34'sd1) ? 32'd1 : ca_r[TS][31:0];
    hnum = {30'd0, sn} << WORK_BITS;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hr_r[0] <= {2'b00, hnum[61:32]};
      hn_r[0] <= hnum[31:0];
      hd_r[0] <= cs;
      hq_r[0] <= '0;
    end
  end

  for (genvar j = 1; j <= OHM_STEPS; j++) begin : g_hdiv
    logic [32:0] rem2;
    logic        ge;
    always_comb begin
      rem2 = {hr_r[j-1], hn_r[j-1][31]};
      ge   = (rem2 >= {1'b0, hd_r[j-1]});
    end
    always_ff @(posedge clk) begin
      if (en) begin
        hr_r[j] <= ge ? 32'(rem2 - {1'b0, hd_r[j-1]}) : rem2[31:0];
        hq_r[j] <= {hq_r[j-1][30:0], ge};
      end
    end
    if (j < OHM_STEPS) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) begin
          hn_r[j] <= {hn_r[j-1][30:0], 1'b0};
          hd_r[j] <= hd_r[j-1];
        end
      end
    end
  end

  // ohm squared and sqrt2 * ohm
  logic [64:0] o2p;
  logic [63:0] s2p;
  always_comb begin
    o2p = 65'(hq_r[OHM_STEPS]) * 65'(hq_r[OHM_STEPS]) + (65'd1 << (WORK_BITS - 1));
    s2p = 64'(SQRT2_Q30) * 64'(hq_r[OHM_STEPS]) + (64'd1 << (WORK_BITS - 1));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ohm2_r <= 35'(o2p >> WORK_BITS);
      s2o_r  <= 34'(s2p >> WORK_BITS);
    end
  end

  // denominator and rounded numerators
  localparam int unsigned NW = CW + COEF_FRAC_BITS + 1;
  logic [CW-1:0] cden;
  logic [36:0]   ns [3];
  logic [CW-1:0] nmag [3];
  logic [NW-1:0] num [3];
  always_comb begin
    cden  = CW'(ONE_W) + CW'(s2o_r) + CW'(ohm2_r);
    ns[0] = 37'(ohm2_r);
    ns[1] = 37'(ohm2_r) - ONE_W;
    ns[2] = ONE_W - 37'(s2o_r) + 37'(ohm2_r);
    for (int i = 0; i < 3; i++) begin
      nmag[i] = ns[i][36] ? CW'(-ns[i]) : ns[i][CW-1:0];
      num[i]  = (NW'(nmag[i]) << COEF_FRAC_BITS) + NW'(cden >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cd_r[0] <= cden;
      for (int i = 0; i < 3; i++) begin
        cr_r[0][i] <= CW'(num[i] >> (COEF_FRAC_BITS + 1));
        cn_r[0][i] <= num[i][COEF_FRAC_BITS:0];
        cq_r[0][i] <= '0;
        cs_r[0][i] <= ns[i][36];
      end
    end
  end

  for (genvar j = 1; j <= COEF_STEPS; j++) begin : g_cdiv
    logic [CW:0] rem2 [3];
    logic        ge [3];
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rem2[i] = {cr_r[j-1][i], cn_r[j-1][i][COEF_FRAC_BITS]};
        ge[i]   = (rem2[i] >= {1'b0, cd_r[j-1]});
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          cr_r[j][i] <= ge[i] ? CW'(rem2[i] - {1'b0, cd_r[j-1]}) : rem2[i][CW-1:0];
          cq_r[j][i] <= {cq_r[j-1][i][COEF_FRAC_BITS-1:0], ge[i]};
          cs_r[j][i] <= cs_r[j-1][i];
        end
      end
    end
    if (j < COEF_STEPS) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) begin
          for (int i = 0; i < 3; i++) begin
            cn_r[j][i] <= {cn_r[j-1][i][COEF_FRAC_BITS-1:0], 1'b0};
          end
          cd_r[j] <= cd_r[j-1];
        end
      end
    end
  end

  // sign, double and saturate
  logic signed [33:0] qs [3];
  logic [31:0]        b0s;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs[i] = cs_r[COEF_STEPS][i] ? -$signed(34'(cq_r[COEF_STEPS][i]))
                                  :  $signed(34'(cq_r[COEF_STEPS][i]));
    end
    b0s = sat32(qs[0]);
    fin.b0 = b0s;
    fin.b1 = sat32($signed({{2{b0s[31]}}, b0s}) <<< 1);
    fin.b2 = b0s;
    fin.a1 = sat32(qs[1] <<< 1);
    fin.a2 = sat32(qs[2]);
    fin.fc = m_r[NUM_STAGES-1].fc;
    fin.pt = m_r[NUM_STAGES-1].pt;
    if (m_r[NUM_STAGES-1].pt) begin
      fin.b0 = '0;
      fin.b1 = '0;
      fin.b2 = '0;
      fin.a1 = '0;
      fin.a2 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_wp_r  <= 1'b0;
      rq_rp_r  <= 1'b0;
      rq_cnt_r <= 2'd0;
    end else begin
      if (rq_push) rq_wp_r <= ~rq_wp_r;
      if (rq_pop) rq_rp_r <= ~rq_rp_r;
      rq_cnt_r <= rq_cnt_r + 2'(rq_push) - 2'(rq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (rq_push) rq_r[rq_wp_r] <= fin;
  end

endmodule

`default_nettype wire

// ----- design/butterworth_biquad_coef_gen_core.sv -----
// Top level of the Butterworth low-pass biquad coefficient generator.
// Instantiates bbcg_front and bbcg_back; uses bbcg_pkg.
//
// Takes one request (sample rate, cutoff; unsigned Q16.8) per clock while full is
// low and returns b0, b1, b2, a1, a2 in signed Q2.30 with the clamped cutoff and a
// pass-through flag. Throughput is one request per cycle unless a full result queue
// stalls the pipeline, which is built from bit-serial pipelined dividers (32 steps
// for fc/fs, 32 for tan, 31 for the coefficients) and the 16-stage Taylor lanes.
// A four-entry request queue and a two-entry result queue decouple both sides.
`timescale 1ns / 1ps
`default_nettype none

module butterworth_biquad_coef_gen_core
  import bbcg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [23:0] in_sample_rate,
  input  logic [23:0] in_cutoff_request,
  output logic        empty,
  input  logic        pop,
  output logic signed [31:0] out_coef_b0,
  output logic signed [31:0] out_coef_b1,
  output logic signed [31:0] out_coef_b2,
  output logic signed [31:0] out_coef_a1,
  output logic signed [31:0] out_coef_a2,
  output logic [23:0] out_effective_cutoff,
  output logic        out_pass_through
);

  logic req_valid, req_pop;
  req_t req;
  res_t res;

  bbcg_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .sample_rate    (in_sample_rate),
    .cutoff_request (in_cutoff_request),
    .req_valid      (req_valid),
    .req            (req),
    .req_pop        (req_pop)
  );

  bbcg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req       (req),
    .req_pop   (req_pop),
    .res_pop   (pop),
    .res_empty (empty),
    .res       (res)
  );

  assign out_coef_b0          = res.b0;
  assign out_coef_b1          = res.b1;
  assign out_coef_b2          = res.b2;
  assign out_coef_a1          = res.a1;
  assign out_coef_a2          = res.a2;
  assign out_effective_cutoff = res.fc;
  assign out_pass_through     = res.pt;

endmodule

`default_nettype wire

// ----- design/bbcg_checker.sv -----
// Port-level checker for the coefficient generator and its bind to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module bbcg_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        empty,
  input wire        pop,
  input wire [31:0] out_coef_b0,
  input wire [31:0] out_coef_b1,
  input wire [31:0] out_coef_b2,
  input wire [31:0] out_coef_a1,
  input wire [31:0] out_coef_a2,
  input wire [23:0] out_effective_cutoff,
  input wire        out_pass_through
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_pt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_pass_through) |-> (out_coef_b0 == 32'd0 && out_coef_b1 == 32'd0 &&
      out_coef_b2 == 32'd0 && out_coef_a1 == 32'd0 && out_coef_a2 == 32'd0 &&
      out_effective_cutoff == 24'd0))
    else $error("pass-through transaction with nonzero fields");

  a_pt_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_pass_through) |-> (out_effective_cutoff != 24'd0))
    else $error("zero cutoff without pass-through");

  a_b_rel: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_pass_through) |->
      (out_coef_b2 == out_coef_b0 && out_coef_b1 == {out_coef_b0[30:0], 1'b0}))
    else $error("feedforward coefficients inconsistent");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_coef_a1) && $stable(out_coef_a2)))
    else $error("stalled transaction changed");

endmodule

bind butterworth_biquad_coef_gen_core bbcg_checker u_bbcg_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .empty                (empty),
  .pop                  (pop),
  .out_coef_b0          (out_coef_b0),
  .out_coef_b1          (out_coef_b1),
  .out_coef_b2          (out_coef_b2),
  .out_coef_a1          (out_coef_a1),
  .out_coef_a2          (out_coef_a2),
  .out_effective_cutoff (out_effective_cutoff),
  .out_pass_through     (out_pass_through)
);

`default_nettype wire

// ----- tb/bbcg_checker.sv -----
// Checker for the Butterworth biquad coefficient generator: predicts each result
// from accepted requests and compares it with popped results. No dependencies.
`timescale 1ns / 1ps

module bbcg_scoreboard (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic        full,
  input  logic [23:0] in_sample_rate,
  input  logic [23:0] in_cutoff_request,
  input  logic        empty,
  input  logic        pop,
  input  logic [31:0] out_coef_b0,
  input  logic [31:0] out_coef_b1,
  input  logic [31:0] out_coef_b2,
  input  logic [31:0] out_coef_a1,
  input  logic [31:0] out_coef_a2,
  input  logic [23:0] out_effective_cutoff,
  input  logic        out_pass_through,
  output int          fail_count,
  output int          pending,
  output int          results_seen,
  output int          pt_seen
);

  typedef struct packed {
    logic [31:0] b0;
    logic [31:0] b1;
    logic [31:0] b2;
    logic [31:0] a1;
    logic [31:0] a2;
    logic [23:0] fc;
    logic        pt;
  } coef_set_t;

  localparam logic [63:0] PI_Q30_C    = 64'hC90FDAA2;
  localparam logic [63:0] SQRT2_Q30_C = 64'd1518500250;
  localparam logic [63:0] ONE_Q30_C   = 64'd1 << 30;

  coef_set_t coef_queue[$];

  function automatic logic [31:0] clip32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7FFFFFFF;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] round_div(input logic signed [63:0] num,
                                                   input logic [63:0] den);
    logic [63:0] mag;
    logic [63:0] q;
    mag = num < 0 ? 64'(-num) : 64'(num);
    q = ((mag << 30) + (den >> 1)) / den;
    return num < 0 ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [63:0] series(input logic [63:0] start,
                                                input logic [63:0] th2,
                                                input logic [63:0] first_div);
    logic [63:0] term;
    logic signed [63:0] acc;
    logic [63:0] n;
    term = start;
    acc = $signed(start);
    n = first_div;
    for (int k = 1; k <= 8; k++) begin
      term = ((term * th2) >> 30) / (n * (n + 1));
      n += 2;
      if (k % 2 == 1) acc -= $signed(term);
      else acc += $signed(term);
    end
    return acc;
  endfunction

  function automatic coef_set_t butterworth_coefs(input logic [23:0] fs_in,
                                                  input logic [23:0] req_in);
    coef_set_t r;
    logic [63:0] fs, limit, fc, x, theta, th2, ohm, ohm2, s2o, c;
    logic signed [63:0] sn, cs, b0, a1, a2, b0s;
    logic [31:0] b0c;
    fs = 64'(fs_in);
    limit = (fs * 2) / 5;
    fc = 64'(req_in) < limit ? 64'(req_in) : limit;
    r = '0;
    r.fc = fc[23:0];
    if (fc == 0) begin
      r.pt = 1'b1;
      return r;
    end
    x = (fc << 32) / fs;
    theta = (x * PI_Q30_C + (64'd1 << 31)) >> 32;
    th2 = (theta * theta + (64'd1 << 29)) >> 30;
    sn = series(theta, th2, 2);
    cs = series(ONE_Q30_C, th2, 1);
    if (sn < 0) sn = 0;
    if (cs < 1) cs = 1;
    ohm = (64'(sn) << 30) / 64'(cs);
    ohm2 = (ohm * ohm + (64'd1 << 29)) >> 30;
    s2o = (SQRT2_Q30_C * ohm + (64'd1 << 29)) >> 30;
    c = ONE_Q30_C + s2o + ohm2;
    b0 = round_div($signed(ohm2), c);
    a1 = 2 * round_div($signed(ohm2) - $signed(ONE_Q30_C), c);
    a2 = round_div($signed(ONE_Q30_C) - $signed(s2o) + $signed(ohm2), c);
    b0c = clip32(b0);
    b0s = $signed({{32{b0c[31]}}, b0c});
    r.b0 = b0c;
    r.b1 = clip32(2 * b0s);
    r.b2 = b0c;
    r.a1 = clip32(a1);
    r.a2 = clip32(a2);
    r.pt = 1'b0;
    return r;
  endfunction

  assign pending = coef_queue.size();

  always @(posedge clk) begin
    coef_set_t got;
    coef_set_t want;
    if (!rst_n) begin
      fail_count <= 0;
      results_seen <= 0;
      pt_seen <= 0;
    end else begin
      if (push && !full) coef_queue.push_back(butterworth_coefs(in_sample_rate,
                                                                in_cutoff_request));
      if (pop && !empty) begin
        got = '{out_coef_b0, out_coef_b1, out_coef_b2, out_coef_a1, out_coef_a2,
                out_effective_cutoff, out_pass_through};
        results_seen <= results_seen + 1;
        if (out_pass_through) pt_seen <= pt_seen + 1;
        if (coef_queue.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("ERROR: unexpected transaction %h", got);
        end else begin
          want = coef_queue.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) begin
              $display("ERROR: mismatch b0 %h/%h b1 %h/%h b2 %h/%h", want.b0, got.b0,
                       want.b1, got.b1, want.b2, got.b2);
              $display("       a1 %h/%h a2 %h/%h fc %h/%h pt %b/%b", want.a1, got.a1,
                       want.a2, got.a2, want.fc, got.fc, want.pt, got.pt);
            end
          end
        end
      end
    end
  end

endmodule

// ----- tb/tb_butterworth_biquad_coef_gen_core.sv -----
// Testbench top for butterworth_biquad_coef_gen_core: drives requests and pops
// results under several idling phases. Depends on the block and bbcg_scoreboard.
`timescale 1ns / 1ps

module tb_butterworth_biquad_coef_gen_core;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 200;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [23:0] in_sample_rate;
  logic [23:0] in_cutoff_request;
  logic        empty;
  logic        pop;
  logic signed [31:0] out_coef_b0, out_coef_b1, out_coef_b2, out_coef_a1, out_coef_a2;
  logic [23:0] out_effective_cutoff;
  logic        out_pass_through;
  int          fail_count, pending, results_seen, pt_seen;
  int          send_idle_pct, recv_idle_pct;
  int          idle_cycles;
  int          sent;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  butterworth_biquad_coef_gen_core dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_sample_rate(in_sample_rate), .in_cutoff_request(in_cutoff_request),
    .empty(empty), .pop(pop),
    .out_coef_b0(out_coef_b0), .out_coef_b1(out_coef_b1), .out_coef_b2(out_coef_b2),
    .out_coef_a1(out_coef_a1), .out_coef_a2(out_coef_a2),
    .out_effective_cutoff(out_effective_cutoff), .out_pass_through(out_pass_through)
  );

  bbcg_scoreboard checker_i (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_sample_rate(in_sample_rate), .in_cutoff_request(in_cutoff_request),
    .empty(empty), .pop(pop),
    .out_coef_b0(out_coef_b0), .out_coef_b1(out_coef_b1), .out_coef_b2(out_coef_b2),
    .out_coef_a1(out_coef_a1), .out_coef_a2(out_coef_a2),
    .out_effective_cutoff(out_effective_cutoff), .out_pass_through(out_pass_through),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen),
    .pt_seen(pt_seen)
  );

  // receiver: random stall per phase
  always @(posedge clk) begin
    if (!rst_n) pop <= 1'b0;
    else pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results pending", pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  // present one request, hold it until accepted
  task automatic send_request(input logic [23:0] fs, input logic [23:0] req);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_sample_rate <= fs;
    in_cutoff_request <= req;
    @(posedge clk);
    while (full) @(posedge clk);
    sent++;
  endtask

  task automatic random_request();
    logic [23:0] fs, req;
    int mode;
    mode = $urandom_range(9);
    fs = 24'($urandom_range(24'hFFFFFF));
    if (mode < 2) fs = 24'($urandom_range(24'hFF));
    case (mode)
      0, 1, 2: req = 24'($urandom_range(24'hFFFFFF));
      3, 4: req = 24'(32'(fs / 5 * 2) + $urandom_range(2) - 32'd1);
      5: req = 24'($urandom_range(3));
      default: req = 24'($urandom_range(32'(fs)));
    endcase
    send_request(fs, req);
  endtask

  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    in_sample_rate = '0;
    in_cutoff_request = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    idle_cycles = 0;
    sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners
    send_request(24'd0, 24'd0);
    send_request(24'd0, 24'hFFFFFF);
    send_request(24'hFFFFFF, 24'd0);
    send_request(24'hFFFFFF, 24'hFFFFFF);
    send_request(24'd1, 24'd1);
    send_request(24'd2, 24'd5);
    send_request(24'd3, 24'd1);
    send_request(24'd5, 24'd2);
    send_request(24'd5, 24'd3);
    send_request(24'hBB8000, 24'h03E800);
    send_request(24'hBB8000, 24'h4B0000);
    send_request(24'hBB8000, 24'h4AFFFF);
    send_request(24'hBB8000, 24'd1);
    send_request(24'hAC4400, 24'h0A0000);
    send_request(24'hAAAAAA, 24'h555555);
    send_request(24'h555555, 24'hAAAAAA);
    send_request(24'h800000, 24'h333333);
    send_request(24'hFFFFFF, 24'h666666);
    send_request(24'h000100, 24'h000066);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 51 : (ph == 3) ? 36 : 0;
      recv_idle_pct = (ph == 2) ? 51 : (ph == 3) ? 36 : 0;
      repeat (320) random_request();
    end
    push <= 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d requests over four idling phases; %0d results checked, %0d pass-through",
             sent, results_seen, pt_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
